@@ rtl/core/rhc_pkg.sv @@
// Shared types and helpers for the RGB to HSV conversion pipeline.
package rhc_pkg;

    localparam int unsigned CompW  = 8;
    localparam int unsigned HueW   = 11;
    localparam int unsigned DivBitsPerStage = 2;
    localparam int unsigned DivStages = CompW / DivBitsPerStage;

    // Hue sextant bases
    localparam logic [HueW-1:0] HUE_RED     = 11'd0;
    localparam logic [HueW-1:0] HUE_YELLOW  = 11'd256;
    localparam logic [HueW-1:0] HUE_GREEN   = 11'd512;
    localparam logic [HueW-1:0] HUE_CYAN    = 11'd768;
    localparam logic [HueW-1:0] HUE_BLUE    = 11'd1024;
    localparam logic [HueW-1:0] HUE_MAGENTA = 11'd1280;
    localparam logic [HueW-1:0] HUE_FULL    = 11'd1536;

    typedef struct packed {
        logic [CompW-1:0] red;
        logic [CompW-1:0] green;
        logic [CompW-1:0] blue;
    } pix_t;

    typedef struct packed {
        logic [HueW-1:0]  hue;
        logic [CompW-1:0] saturation;
        logic [CompW-1:0] brightness;
    } hsv_t;

    // One restoring divider lane: 255*num / den, quotient known to fit 8 bits
    typedef struct packed {
        logic [CompW-1:0] rem;
        logic [CompW-1:0] low;
        logic [CompW-1:0] den;
        logic [CompW-1:0] quo;
    } div_lane_t;

    typedef struct packed {
        logic [HueW-1:0]  base;
        logic             neg;
        logic [CompW-1:0] value;
    } side_t;

    typedef struct packed {
        div_lane_t hue_div;
        div_lane_t sat_div;
        side_t     side;
    } stage_t;

    // Load a lane with dividend 255*num; upper byte is below den by construction
    function automatic div_lane_t div_load(input logic [CompW-1:0] num,
                                           input logic [CompW-1:0] den);
        logic [2*CompW-1:0] prod;
        div_lane_t          lane;
        prod      = {num, {CompW{1'b0}}} - {{CompW{1'b0}}, num};
        lane.rem  = prod[2*CompW-1:CompW];
        lane.low  = prod[CompW-1:0];
        lane.den  = den;
        lane.quo  = '0;
        return lane;
    endfunction

    // One quotient bit of restoring division
    function automatic div_lane_t div_step(input div_lane_t lane_in);
        logic [CompW:0] trial;
        logic [CompW:0] diff;
        div_lane_t      lane;
        lane  = lane_in;
        trial = {lane_in.rem, lane_in.low[CompW-1]};
        diff  = trial - {1'b0, lane_in.den};
        if (trial >= {1'b0, lane_in.den})
        begin
            lane.rem = diff[CompW-1:0];
            lane.quo = {lane_in.quo[CompW-2:0], 1'b1};
        end
        else
        begin
            lane.rem = trial[CompW-1:0];
            lane.quo = {lane_in.quo[CompW-2:0], 1'b0};
        end
        lane.low = {lane_in.low[CompW-2:0], 1'b0};
        return lane;
    endfunction

endpackage

@@ rtl/core/rhc_div_stage.sv @@
// One pipeline stage retiring two quotient bits of both dividers.
module rhc_div_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            up_valid,
    output logic            up_ready,
    input  rhc_pkg::stage_t up_data,
    output logic            dn_valid,
    input  logic            dn_ready,
    output rhc_pkg::stage_t dn_data
);
    import rhc_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    stage_t data_reg;
    stage_t data_next;

    // Stage advances when empty or when downstream takes its item
    assign up_ready = !valid_reg || dn_ready;
    assign valid_next = up_ready ? up_valid : valid_reg;

    // Two restoring steps per lane
    always_comb
    begin
        data_next = up_data;
        for (int i = 0; i < DivBitsPerStage; i++)
        begin
            data_next.hue_div = div_step(data_next.hue_div);
            data_next.sat_div = div_step(data_next.sat_div);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

@@ rtl/core/rgb_to_hsv_convert_unit.sv @@
// Top level: pipelined 8-bit RGB to integer HSV conversion, one pixel per cycle while hsv_ready is high.
// Pipeline: 6 register stages (1 setup, 4 divide, 1 output).
// Throughput: one item per cycle when the output does not stall; each divide stage retires two quotient bits.
// Stalls back up stage by stage; bubbles are squeezed out, nothing is lost or repeated.
// Reset clears all valid bits; data registers are not reset.
module rgb_to_hsv_convert_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          pix_valid,
    output logic          pix_ready,
    input  rhc_pkg::pix_t pix,
    output logic          hsv_valid,
    input  logic          hsv_ready,
    output rhc_pkg::hsv_t hsv
);
    import rhc_pkg::*;

    logic [CompW-1:0] r;
    logic [CompW-1:0] g;
    logic [CompW-1:0] b;
    logic [CompW-1:0] vmax;
    logic [CompW-1:0] vmin;
    logic [CompW-1:0] chroma;
    logic [CompW-1:0] hdiff;
    logic [CompW-1:0] hden;
    logic [CompW-1:0] sden;
    stage_t           setup_next;
    logic             setup_valid_reg;
    stage_t           setup_reg;

    stage_t           chain_data  [0:DivStages];
    logic             chain_valid [0:DivStages];
    logic             chain_ready [0:DivStages];

    logic             out_valid_reg;
    hsv_t             out_reg;
    hsv_t             out_next;
    logic             out_take;

    assign r = pix.red;
    assign g = pix.green;
    assign b = pix.blue;

    // Max, min and chroma
    always_comb
    begin
        vmax = (r > g) ? r : g;
        if (b > vmax)
            vmax = b;
        vmin = (r < g) ? r : g;
        if (b < vmin)
            vmin = b;
        chroma = vmax - vmin;
    end

    // Sextant base, direction and hue numerator; boundaries divide zero by one
    always_comb
    begin
        setup_next.side.value = vmax;
        setup_next.side.neg   = 1'b0;
        setup_next.side.base  = HUE_RED;
        hdiff = '0;
        hden  = 8'd1;
        if (r == g && g == b)
        begin
            setup_next.side.base = HUE_RED;
        end
        else if (r == g)
        begin
            setup_next.side.base = (r > b) ? HUE_YELLOW : HUE_BLUE;
        end
        else if (g == b)
        begin
            setup_next.side.base = (g > r) ? HUE_CYAN : HUE_RED;
        end
        else if (b == r)
        begin
            setup_next.side.base = (r > g) ? HUE_MAGENTA : HUE_GREEN;
        end
        else
        begin
            hden = chroma;
            if (vmax == r)
            begin
                if (g > b)
                begin
                    setup_next.side.base = HUE_RED;
                    hdiff = g - b;
                end
                else
                begin
                    setup_next.side.base = HUE_FULL;
                    setup_next.side.neg  = 1'b1;
                    hdiff = b - g;
                end
            end
            else if (vmax == g)
            begin
                setup_next.side.base = HUE_GREEN;
                setup_next.side.neg  = !(b > r);
                hdiff = (b > r) ? (b - r) : (r - b);
            end
            else
            begin
                setup_next.side.base = HUE_BLUE;
                setup_next.side.neg  = !(r > g);
                hdiff = (r > g) ? (r - g) : (g - r);
            end
        end
        // Black: chroma is zero, so a unit divisor gives saturation zero
        sden = (vmax == '0) ? 8'd1 : vmax;
        setup_next.hue_div = div_load(hdiff, hden);
        setup_next.sat_div = div_load(chroma, sden);
    end

    // Setup stage register
    assign pix_ready = !setup_valid_reg || chain_ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            setup_valid_reg <= 1'b0;
        else if (pix_ready)
            setup_valid_reg <= pix_valid;
    end

    always_ff @(posedge clk)
    begin
        if (pix_ready && pix_valid)
            setup_reg <= setup_next;
    end

    assign chain_data[0]  = setup_reg;
    assign chain_valid[0] = setup_valid_reg;

    // Divider stages
    for (genvar k = 0; k < DivStages; k++)
    begin : g_div
        rhc_div_stage u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (chain_valid[k]),
            .up_ready (chain_ready[k]),
            .up_data  (chain_data[k]),
            .dn_valid (chain_valid[k+1]),
            .dn_ready (chain_ready[k+1]),
            .dn_data  (chain_data[k+1])
        );
    end

    // Final hue assembly and output register
    assign chain_ready[DivStages] = !out_valid_reg || hsv_ready;
    assign out_take = chain_ready[DivStages] && chain_valid[DivStages];

    always_comb
    begin
        out_next.hue = chain_data[DivStages].side.neg
            ? chain_data[DivStages].side.base - {3'b000, chain_data[DivStages].hue_div.quo}
            : chain_data[DivStages].side.base + {3'b000, chain_data[DivStages].hue_div.quo};
        out_next.saturation = chain_data[DivStages].sat_div.quo;
        out_next.brightness = chain_data[DivStages].side.value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (chain_ready[DivStages])
            out_valid_reg <= chain_valid[DivStages];
    end

    always_ff @(posedge clk)
    begin
        if (out_take)
            out_reg <= out_next;
    end

    assign hsv_valid = out_valid_reg;
    assign hsv       = out_reg;

endmodule

@@ bench/tb.sv @@
// Self-checking testbench for the pipelined RGB to HSV conversion unit.
`timescale 1ns / 100ps

module tb;
    import rhc_pkg::*;

    localparam int unsigned IdleLimit   = 2000;
    localparam int unsigned DrainCycles = 20;
    localparam int unsigned MaxReported = 10;

    logic  clk;
    logic  rst_n;
    logic  pix_valid;
    logic  pix_ready;
    pix_t  pix;
    logic  hsv_valid;
    logic  hsv_ready;
    hsv_t  hsv;

    // Predicted results, oldest first
    hsv_t        pending_hsv[$];
    int unsigned mismatch_count;
    int unsigned idle_cycles;
    bit          gaps_on;
    bit          stalls_on;

    rgb_to_hsv_convert_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix),
        .hsv_valid (hsv_valid),
        .hsv_ready (hsv_ready),
        .hsv       (hsv)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // 255 * num / den, truncated
    function automatic int unsigned scale_ratio(input int unsigned num, input int unsigned den);
        if (den == 0)
            return 0;
        return (255 * num) / den;
    endfunction

    // Expected HSV for one pixel
    function automatic hsv_t convert_pixel(input pix_t p);
        int unsigned r;
        int unsigned g;
        int unsigned b;
        int unsigned hi;
        int unsigned lo;
        int unsigned chroma;
        int unsigned h;
        int unsigned s;
        hsv_t        res;
        r = int'(p.red);
        g = int'(p.green);
        b = int'(p.blue);
        if (r == g && g == b)
        begin
            // gray, black included
            h  = int'(HUE_RED);
            s  = 0;
            hi = b;
        end
        else if (r == g)
        begin
            if (r > b)
            begin
                h = int'(HUE_YELLOW); hi = r; lo = b;
            end
            else
            begin
                h = int'(HUE_BLUE); hi = b; lo = r;
            end
            s = scale_ratio(hi - lo, hi);
        end
        else if (g == b)
        begin
            if (g > r)
            begin
                h = int'(HUE_CYAN); hi = g; lo = r;
            end
            else
            begin
                h = int'(HUE_RED); hi = r; lo = g;
            end
            s = scale_ratio(hi - lo, hi);
        end
        else if (b == r)
        begin
            if (r > g)
            begin
                h = int'(HUE_MAGENTA); hi = r; lo = g;
            end
            else
            begin
                h = int'(HUE_GREEN); hi = g; lo = r;
            end
            s = scale_ratio(hi - lo, hi);
        end
        else
        begin
            // all three distinct
            hi = (r > g) ? r : g;
            if (b > hi)
                hi = b;
            lo = (r < g) ? r : g;
            if (b < lo)
                lo = b;
            chroma = hi - lo;
            if (hi == r)
            begin
                if (g > b)
                    h = scale_ratio(g - b, chroma);
                else
                    h = int'(HUE_FULL) - scale_ratio(b - g, chroma);
            end
            else if (hi == g)
            begin
                if (b > r)
                    h = int'(HUE_GREEN) + scale_ratio(b - r, chroma);
                else
                    h = int'(HUE_GREEN) - scale_ratio(r - b, chroma);
            end
            else
            begin
                if (r > g)
                    h = int'(HUE_BLUE) + scale_ratio(r - g, chroma);
                else
                    h = int'(HUE_BLUE) - scale_ratio(g - r, chroma);
            end
            s = scale_ratio(chroma, hi);
        end
        res.hue        = h[HueW-1:0];
        res.saturation = s[CompW-1:0];
        res.brightness = hi[CompW-1:0];
        return res;
    endfunction

    function automatic pix_t make_pix(input int unsigned r, input int unsigned g,
                                      input int unsigned b);
        pix_t p;
        p.red   = r[CompW-1:0];
        p.green = g[CompW-1:0];
        p.blue  = b[CompW-1:0];
        return p;
    endfunction

    // Random pixel: a mix of uniform, gray, equal-pair and low-chroma pixels
    function automatic pix_t random_pix();
        int unsigned kind;
        int unsigned a;
        int unsigned c;
        int unsigned base;
        kind = $urandom_range(0, 7);
        a    = $urandom_range(0, 255);
        c    = $urandom_range(0, 255);
        case (kind)
            0: return make_pix(a, a, a);
            1: return make_pix(a, a, c);
            2: return make_pix(c, a, a);
            3: return make_pix(a, c, a);
            4:
            begin
                base = $urandom_range(0, 252);
                return make_pix(base + $urandom_range(0, 3), base + $urandom_range(0, 3),
                                base + $urandom_range(0, 3));
            end
            default: return make_pix(a, c, $urandom_range(0, 255));
        endcase
    endfunction

    // Send one item; may idle first, holds valid and payload until accepted
    task automatic send_pixel(input pix_t p);
        int unsigned gap;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 4);
            pix_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix       <= p;
        do
            @(posedge clk);
        while (!pix_ready);
        pending_hsv.push_back(convert_pixel(p));
    endtask

    // Compare one accepted result with the oldest prediction
    task automatic check_result(input hsv_t got);
        hsv_t want;
        if (pending_hsv.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= MaxReported)
                $display("ERROR: unexpected result hue=%0d sat=%0d val=%0d",
                         got.hue, got.saturation, got.brightness);
        end
        else
        begin
            want = pending_hsv.pop_front();
            if (got.hue !== want.hue || got.saturation !== want.saturation ||
                got.brightness !== want.brightness)
            begin
                mismatch_count++;
                if (mismatch_count <= MaxReported)
                    $display("ERROR: hue %0d/%0d sat %0d/%0d val %0d/%0d (expected/actual)",
                             want.hue, got.hue, want.saturation, got.saturation,
                             want.brightness, got.brightness);
            end
        end
    endtask

    // Output side: check accepted results, stall in random bursts
    initial
    begin
        int unsigned stall_left;
        stall_left = 0;
        hsv_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && hsv_valid && hsv_ready)
                check_result(hsv);
            if (stall_left > 0)
            begin
                stall_left--;
                hsv_ready <= 1'b0;
            end
            else if (stalls_on && $urandom_range(0, 3) == 0)
            begin
                stall_left = $urandom_range(1, 4) - 1;
                hsv_ready <= 1'b0;
            end
            else
                hsv_ready <= 1'b1;
        end
    end

    // Watchdog on cycles with no handshake on either side
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n || (pix_valid && pix_ready) || (hsv_valid && hsv_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IdleLimit)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Gray pixels, black and white included
    task automatic test_gray();
        send_pixel(make_pix(0, 0, 0));
        send_pixel(make_pix(255, 255, 255));
        send_pixel(make_pix(128, 128, 128));
    endtask

    // Two equal components: both sides of each sextant boundary
    task automatic test_equal_pairs();
        send_pixel(make_pix(200, 200, 10));
        send_pixel(make_pix(5, 5, 250));
        send_pixel(make_pix(0, 255, 255));
        send_pixel(make_pix(255, 1, 1));
        send_pixel(make_pix(255, 0, 255));
        send_pixel(make_pix(3, 254, 3));
    endtask

    // Distinct components: each max and each rising or falling slope
    task automatic test_sextants();
        send_pixel(make_pix(255, 128, 0));
        send_pixel(make_pix(255, 0, 128));
        send_pixel(make_pix(0, 255, 128));
        send_pixel(make_pix(128, 255, 0));
        send_pixel(make_pix(128, 0, 255));
        send_pixel(make_pix(0, 128, 255));
        send_pixel(make_pix(2, 1, 0));
        send_pixel(make_pix(255, 254, 253));
        send_pixel(make_pix(1, 0, 2));
        send_pixel(make_pix('hAA, 'h55, 'h0F));
        send_pixel(make_pix('h55, 'hAA, 'hF0));
    endtask

    // Random pixels under a given idling mix
    task automatic test_random(input int unsigned count, input bit gaps, input bit stalls);
        gaps_on   = gaps;
        stalls_on = stalls;
        repeat (count)
            send_pixel(random_pix());
    endtask

    // Sender holds off until the pipeline has emptied
    task automatic test_drain_pause();
        pix_valid <= 1'b0;
        while (pending_hsv.size() != 0)
            @(posedge clk);
        repeat ($urandom_range(1, 8)) @(posedge clk);
    endtask

    // Main sequence
    initial
    begin
        mismatch_count = 0;
        gaps_on        = 1'b1;
        stalls_on      = 1'b1;
        rst_n     <= 1'b0;
        pix_valid <= 1'b0;
        pix       <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_gray();
        test_equal_pairs();
        test_sextants();
        test_random(200, 1'b1, 1'b1);
        test_drain_pause();
        test_random(100, 1'b1, 1'b0);
        test_random(100, 1'b0, 1'b1);
        test_drain_pause();
        test_random(200, 1'b0, 1'b0);

        // Drain and let any stray result show up
        pix_valid <= 1'b0;
        while (pending_hsv.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/rhc_pkg.sv
rtl/core/rhc_div_stage.sv
rtl/core/rgb_to_hsv_convert_unit.sv
bench/tb.sv
